// ===== rtl/hrz_pkg.sv =====
// Shared types, constants and the zone mapping for the heart-rate zone tracker.
// Used by every module of the block; depends on nothing.
`default_nettype none
package hrz_pkg;

    localparam int HR_W    = 8;
    localparam int TIME_W  = 32;
    localparam int PCT_W   = 8;
    localparam int ZONE_W  = 3;
    localparam int SECS_W  = 16;
    localparam int MODE_W  = 2;
    localparam int CIDX_W  = 2;
    localparam int CDAT_W  = 8;
    localparam int DIGIT_W = 2;
    localparam int STEPS   = TIME_W / DIGIT_W;
    localparam int CNT_W   = $clog2(STEPS);
    localparam int DIVD_W  = 15;
    localparam int REM_W   = PCT_W + 1;
    localparam int NUM_ZONES = 6;

    localparam logic [HR_W-1:0]   HR_INVALID_LO = 8'd0;
    localparam logic [HR_W-1:0]   HR_INVALID_HI = 8'd255;
    localparam logic [PCT_W-1:0]  PCT_SAT       = 8'd255;
    localparam logic [PCT_W-1:0]  PCT_ZONE2     = 8'd60;
    localparam logic [PCT_W-1:0]  PCT_ZONE3     = 8'd70;
    localparam logic [PCT_W-1:0]  PCT_ZONE4     = 8'd80;
    localparam logic [PCT_W-1:0]  PCT_ZONE5     = 8'd90;
    localparam logic [ZONE_W-1:0] ZONE_1        = 3'd1;
    localparam logic [ZONE_W-1:0] ZONE_2        = 3'd2;
    localparam logic [ZONE_W-1:0] ZONE_3        = 3'd3;
    localparam logic [ZONE_W-1:0] ZONE_4        = 3'd4;
    localparam logic [ZONE_W-1:0] ZONE_5        = 3'd5;
    localparam logic [SECS_W-1:0] DELTA_SAT     = 16'hFFFF;

    localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DWELL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PEAK  = 2'd2;

    localparam logic [CIDX_W-1:0] REG_MAX_HR = 2'd0;
    localparam logic [CIDX_W-1:0] REG_MODE   = 2'd1;
    localparam logic [CIDX_W-1:0] REG_DWELL  = 2'd2;

    localparam logic [HR_W-1:0]   RST_MAX_HR = 8'd190;
    localparam logic [MODE_W-1:0] RST_MODE   = MODE_OFF;
    localparam logic [HR_W-1:0]   RST_DWELL  = 8'd30;

    // control for the serial units: load operands, step one digit, low half
    typedef struct packed {
        logic ld;
        logic en;
        logic lo;
    } t_ser_ctl;

    // what the serial subtractor leaves once all digits have passed
    typedef struct packed {
        logic [SECS_W-1:0] lo;
        logic              hi_nz;
        logic              b_nz;
    } t_diff;

    function automatic logic [ZONE_W-1:0] f_zone(input logic [PCT_W-1:0] pct);
        logic [ZONE_W-1:0] z;
        if (pct < PCT_ZONE2)      z = ZONE_1;
        else if (pct < PCT_ZONE3) z = ZONE_2;
        else if (pct < PCT_ZONE4) z = ZONE_3;
        else if (pct < PCT_ZONE5) z = ZONE_4;
        else                      z = ZONE_5;
        return z;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/hrz_div.sv =====
// Bit-serial restoring divider: percent = 100 * heart rate / max rate, saturated.
// One quotient bit per step; uses hrz_pkg.
`default_nettype none
module hrz_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_ld,
    input  wire logic                        i_en,
    input  wire logic [hrz_pkg::HR_W-1:0]    i_hr,
    input  wire logic [hrz_pkg::HR_W-1:0]    i_den,
    output logic      [hrz_pkg::PCT_W-1:0]   o_pct
);
    logic [hrz_pkg::DIVD_W-1:0] r_divd, n_divd;
    logic [hrz_pkg::REM_W-1:0]  r_rem, n_rem;
    logic [hrz_pkg::PCT_W-1:0]  r_q, n_q;
    logic [hrz_pkg::HR_W-1:0]   r_den;
    logic                       r_ovf, n_ovf;
    logic [hrz_pkg::DIVD_W-1:0] hr_ext;
    logic [hrz_pkg::REM_W-1:0]  trial;
    logic                       ge;

    // 100 * hr as shifts and adds
    assign hr_ext = hrz_pkg::DIVD_W'(i_hr);
    assign trial  = {r_rem[hrz_pkg::REM_W-2:0], r_divd[hrz_pkg::DIVD_W-1]};
    assign ge     = trial >= {1'b0, r_den};

    always_comb begin
        n_divd = r_divd;
        n_rem  = r_rem;
        n_q    = r_q;
        n_ovf  = r_ovf;
        if (i_ld) begin
            n_divd = (hr_ext << 6) + (hr_ext << 5) + (hr_ext << 2);
            n_rem  = '0;
            n_q    = '0;
            n_ovf  = 1'b0;
        end else if (i_en) begin
            n_divd = {r_divd[hrz_pkg::DIVD_W-2:0], 1'b0};
            n_rem  = ge ? trial - {1'b0, r_den} : trial;
            n_q    = {r_q[hrz_pkg::PCT_W-2:0], ge};
            // a quotient bit falling off the top means the percent exceeds 255
            n_ovf  = r_ovf | r_q[hrz_pkg::PCT_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_divd <= n_divd;
        r_rem  <= n_rem;
        r_q    <= n_q;
        if (i_ld) r_den <= i_den;
        if (!i_rst_n) r_ovf <= 1'b0;
        else          r_ovf <= n_ovf;
    end

    assign o_pct = r_ovf ? hrz_pkg::PCT_SAT : r_q;
endmodule
`default_nettype wire

// ===== rtl/hrz_tsub.sv =====
// Digit-serial timestamp subtractor a - b, two bits per step, least significant first.
// Keeps the low half of the difference, a high-half flag and a nonzero-b flag; uses hrz_pkg.
`default_nettype none
module hrz_tsub (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire hrz_pkg::t_ser_ctl            i_ctl,
    input  wire logic [hrz_pkg::TIME_W-1:0]   i_a,
    input  wire logic [hrz_pkg::TIME_W-1:0]   i_b,
    output hrz_pkg::t_diff                    o_diff
);
    logic [hrz_pkg::TIME_W-1:0]  r_a, r_b;
    logic [hrz_pkg::SECS_W-1:0]  r_lo;
    logic                        r_c, r_hi_nz, r_b_nz;
    logic [hrz_pkg::DIGIT_W:0]   dsum;

    assign dsum = {1'b0, r_a[hrz_pkg::DIGIT_W-1:0]}
                + {1'b0, ~r_b[hrz_pkg::DIGIT_W-1:0]}
                + {{hrz_pkg::DIGIT_W{1'b0}}, r_c};

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld) begin
            r_a <= i_a;
            r_b <= i_b;
        end else if (i_ctl.en) begin
            r_a <= r_a >> hrz_pkg::DIGIT_W;
            r_b <= r_b >> hrz_pkg::DIGIT_W;
            if (i_ctl.lo)
                r_lo <= {dsum[hrz_pkg::DIGIT_W-1:0], r_lo[hrz_pkg::SECS_W-1:hrz_pkg::DIGIT_W]};
        end
        if (!i_rst_n) begin
            r_c     <= 1'b1;
            r_hi_nz <= 1'b0;
            r_b_nz  <= 1'b0;
        end else if (i_ctl.ld) begin
            r_c     <= 1'b1;
            r_hi_nz <= 1'b0;
            r_b_nz  <= 1'b0;
        end else if (i_ctl.en) begin
            r_c     <= dsum[hrz_pkg::DIGIT_W];
            r_b_nz  <= r_b_nz | (|r_b[hrz_pkg::DIGIT_W-1:0]);
            if (!i_ctl.lo)
                r_hi_nz <= r_hi_nz | (|dsum[hrz_pkg::DIGIT_W-1:0]);
        end
    end

    assign o_diff.lo    = r_lo;
    assign o_diff.hi_nz = r_hi_nz;
    assign o_diff.b_nz  = r_b_nz;
endmodule
`default_nettype wire

// ===== rtl/hrz_dur.sv =====
// Per-zone duration counters with saturating add, one entry read and written a cycle.
// Uses hrz_pkg.
`default_nettype none
module hrz_dur #(
    parameter int DURATION_WIDTH = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [hrz_pkg::ZONE_W-1:0]   i_addr,
    input  wire logic [hrz_pkg::SECS_W-1:0]   i_delta,
    input  wire logic                         i_we,
    output logic      [hrz_pkg::SECS_W-1:0]   o_secs
);
    localparam int SW = ((DURATION_WIDTH > hrz_pkg::SECS_W) ? DURATION_WIDTH
                                                            : hrz_pkg::SECS_W) + 1;
    localparam logic [SW-1:0] DMAX = SW'((64'd1 << DURATION_WIDTH) - 64'd1);

    logic [DURATION_WIDTH-1:0] r_cnt [hrz_pkg::NUM_ZONES];
    logic [DURATION_WIDTH-1:0] rd;
    logic [SW-1:0]             sum, sat;
    logic                      in_range;

    assign in_range = i_addr < hrz_pkg::ZONE_W'(hrz_pkg::NUM_ZONES);
    assign rd       = in_range ? r_cnt[i_addr] : '0;
    assign sum      = SW'(rd) + SW'(i_delta);
    assign sat      = (sum > DMAX) ? DMAX : sum;
    assign o_secs   = sat[hrz_pkg::SECS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < hrz_pkg::NUM_ZONES; k++) r_cnt[k] <= '0;
        end else if (i_we && in_range) begin
            r_cnt[i_addr] <= sat[DURATION_WIDTH-1:0];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/heart_rate_zone_tracker.sv =====
// Heart-rate zone tracker: percent of max rate, zone, per-zone time and vibrate request.
// A valid sample passes through S_RUN, where the 2-bit timestamp subtractors and the
// bit-serial divider step, then S_PREV and S_ZONE, which waits while a result is held.
// A new sample is taken only in S_IDLE; samples of 0 or 255 are dropped with no result.
// Reset (synchronous, active low) restores register defaults and clears all counters.
// Uses hrz_pkg, hrz_div, hrz_tsub, hrz_dur.
`default_nettype none
module heart_rate_zone_tracker #(
    parameter int DURATION_WIDTH = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [hrz_pkg::CIDX_W-1:0]   i_cfg_idx,
    input  wire logic [hrz_pkg::CDAT_W-1:0]   i_cfg_data,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [hrz_pkg::HR_W-1:0]     i_heart_rate,
    input  wire logic [hrz_pkg::TIME_W-1:0]   i_now_seconds,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic      [hrz_pkg::ZONE_W-1:0]   o_zone_number,
    output logic      [hrz_pkg::SECS_W-1:0]   o_zone_seconds,
    output logic      [hrz_pkg::PCT_W-1:0]    o_percent_of_max,
    output logic                              o_vibrate
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_PREV = 2'd2;
    localparam logic [1:0] S_ZONE = 2'd3;
    localparam logic [hrz_pkg::CNT_W-1:0] CNT_LAST = hrz_pkg::CNT_W'(hrz_pkg::STEPS - 1);

    logic [1:0]                   r_state, n_state;
    logic [hrz_pkg::CNT_W-1:0]    r_cnt;
    logic [hrz_pkg::HR_W-1:0]     r_max_hr, r_dwell;
    logic [hrz_pkg::MODE_W-1:0]   r_mode;
    logic [hrz_pkg::TIME_W-1:0]   r_last_time, r_entry_time, r_now;
    logic [hrz_pkg::ZONE_W-1:0]   r_prev_zone, r_zone;
    logic [hrz_pkg::PCT_W-1:0]    r_pct;
    logic                         r_chg, r_vib;
    logic                         r_o_valid, r_o_vib;
    logic [hrz_pkg::ZONE_W-1:0]   r_o_zone;
    logic [hrz_pkg::SECS_W-1:0]   r_o_secs;
    logic [hrz_pkg::PCT_W-1:0]    r_o_pct;

    hrz_pkg::t_ser_ctl            ctl;
    hrz_pkg::t_diff               d_last, d_entry;
    logic [hrz_pkg::PCT_W-1:0]    div_pct;
    logic [hrz_pkg::ZONE_W-1:0]   n_zone, dur_addr;
    logic [hrz_pkg::SECS_W-1:0]   delta, dur_secs;
    logic                         accept, in_ok, out_free, chg_now, dwell_gt, vib_now, dur_we;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign in_ok    = (i_heart_rate != hrz_pkg::HR_INVALID_LO) &&
                      (i_heart_rate != hrz_pkg::HR_INVALID_HI);
    assign out_free = !r_o_valid || i_ready;

    assign ctl.ld = accept && in_ok;
    assign ctl.en = r_state == S_RUN;
    assign ctl.lo = !r_cnt[hrz_pkg::CNT_W-1];

    hrz_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ld    (ctl.ld),
        .i_en    (ctl.en && (r_cnt != CNT_LAST)),
        .i_hr    (i_heart_rate),
        .i_den   (r_max_hr),
        .o_pct   (div_pct)
    );

    hrz_tsub u_sub_last (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_a     (i_now_seconds),
        .i_b     (r_last_time),
        .o_diff  (d_last)
    );

    hrz_tsub u_sub_entry (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_a     (i_now_seconds),
        .i_b     (r_entry_time),
        .o_diff  (d_entry)
    );

    // no previous sample: no time to charge
    assign delta = !d_last.b_nz ? '0 : (d_last.hi_nz ? hrz_pkg::DELTA_SAT : d_last.lo);

    assign n_zone   = hrz_pkg::f_zone(div_pct);
    assign chg_now  = n_zone != r_prev_zone;
    assign dwell_gt = d_entry.hi_nz || (|d_entry.lo[hrz_pkg::SECS_W-1:hrz_pkg::HR_W]) ||
                      (d_entry.lo[hrz_pkg::HR_W-1:0] > r_dwell);
    assign vib_now  = chg_now &&
                      (((r_mode == hrz_pkg::MODE_DWELL) && d_entry.b_nz && dwell_gt) ||
                       ((r_mode == hrz_pkg::MODE_PEAK) && (n_zone == hrz_pkg::ZONE_5)));

    // charge the zone being left first, then the current zone
    assign dur_addr = (r_state == S_PREV) ? r_prev_zone : r_zone;
    assign dur_we   = ((r_state == S_PREV) && chg_now) || ((r_state == S_ZONE) && out_free);

    hrz_dur #(
        .DURATION_WIDTH (DURATION_WIDTH)
    ) u_dur (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_addr  (dur_addr),
        .i_delta (delta),
        .i_we    (dur_we),
        .o_secs  (dur_secs)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (ctl.ld) n_state = S_RUN;
            S_RUN:  if (r_cnt == CNT_LAST) n_state = S_PREV;
            S_PREV: n_state = S_ZONE;
            S_ZONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ctl.ld) r_now <= i_now_seconds;
        if (r_state == S_PREV) begin
            r_zone <= n_zone;
            r_pct  <= div_pct;
            r_chg  <= chg_now;
            r_vib  <= vib_now;
        end
        if ((r_state == S_ZONE) && out_free) begin
            r_o_zone <= r_zone;
            r_o_secs <= dur_secs;
            r_o_pct  <= r_pct;
            r_o_vib  <= r_vib;
        end

        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_max_hr     <= hrz_pkg::RST_MAX_HR;
            r_mode       <= hrz_pkg::RST_MODE;
            r_dwell      <= hrz_pkg::RST_DWELL;
            r_last_time  <= '0;
            r_entry_time <= '0;
            r_prev_zone  <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= ctl.en ? r_cnt + 1'b1 : '0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    hrz_pkg::REG_MAX_HR: r_max_hr <= i_cfg_data;
                    hrz_pkg::REG_MODE:   r_mode   <= i_cfg_data[hrz_pkg::MODE_W-1:0];
                    hrz_pkg::REG_DWELL:  r_dwell  <= i_cfg_data;
                    default: ;
                endcase
            end
            // commit the item's state together with its result
            if ((r_state == S_ZONE) && out_free) begin
                r_last_time <= r_now;
                r_prev_zone <= r_zone;
                if (r_chg) r_entry_time <= r_now;
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_ready          = r_state == S_IDLE;
    assign o_valid          = r_o_valid;
    assign o_zone_number    = r_o_zone;
    assign o_zone_seconds   = r_o_secs;
    assign o_percent_of_max = r_o_pct;
    assign o_vibrate        = r_o_vib;
endmodule
`default_nettype wire

// ===== rtl/hrz_chk.sv =====
// Port-level checks for the heart-rate zone tracker, bound to the top level.
// Uses hrz_pkg.
`default_nettype none
module hrz_chk (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_valid,
    input wire logic                         o_ready,
    input wire logic [hrz_pkg::HR_W-1:0]     i_heart_rate,
    input wire logic                         o_valid,
    input wire logic                         i_ready,
    input wire logic [hrz_pkg::ZONE_W-1:0]   o_zone_number,
    input wire logic [hrz_pkg::SECS_W-1:0]   o_zone_seconds,
    input wire logic [hrz_pkg::PCT_W-1:0]    o_percent_of_max,
    input wire logic                         o_vibrate
);
    // a held result does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_zone_number) &&
        $stable(o_zone_seconds) && $stable(o_percent_of_max) && $stable(o_vibrate))
        else $error("result changed while stalled");

    a_zone_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_zone_number >= hrz_pkg::ZONE_1) && (o_zone_number <= hrz_pkg::ZONE_5))
        else $error("zone out of range");

    a_zone_pct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_zone_number == hrz_pkg::ZONE_1) == (o_percent_of_max < hrz_pkg::PCT_ZONE2))
                 && ((o_zone_number == hrz_pkg::ZONE_5) == (o_percent_of_max >= hrz_pkg::PCT_ZONE5)))
        else $error("zone does not match percent");

    // a valid sample occupies the block
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_heart_rate != hrz_pkg::HR_INVALID_LO) &&
        (i_heart_rate != hrz_pkg::HR_INVALID_HI) |=> !o_ready)
        else $error("ready after accepting a valid sample");
endmodule

bind heart_rate_zone_tracker hrz_chk u_hrz_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .i_heart_rate     (i_heart_rate),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_zone_number    (o_zone_number),
    .o_zone_seconds   (o_zone_seconds),
    .o_percent_of_max (o_percent_of_max),
    .o_vibrate        (o_vibrate)
);
`default_nettype wire

// ===== verif/tb_heart_rate_zone_tracker.sv =====
// Self-checking testbench for heart_rate_zone_tracker: a directed plan, then random samples
// under several register settings, each result checked against an in-bench zone predictor.
// Depends on rtl/hrz_pkg.sv and rtl/heart_rate_zone_tracker.sv.
`timescale 1ns / 100ps
module tb_heart_rate_zone_tracker;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int SEGMENTS      = 8;
    localparam int SEG_SAMPLES   = 100;
    localparam int PRINT_CAP     = 40;
    localparam logic [hrz_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [hrz_pkg::CIDX_W-1:0] REG_UNUSED  = 2'd3;

    typedef struct packed {
        logic [hrz_pkg::ZONE_W-1:0] zone;
        logic [hrz_pkg::SECS_W-1:0] secs;
        logic [hrz_pkg::PCT_W-1:0]  pct;
        logic                       vib;
    } t_zone_result;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind                  kind;
        logic [hrz_pkg::HR_W-1:0]   hr;
        logic [hrz_pkg::TIME_W-1:0] stamp;
        logic [hrz_pkg::CIDX_W-1:0] idx;
        logic [hrz_pkg::CDAT_W-1:0] data;
        bit                         typed;
        logic [hrz_pkg::ZONE_W-1:0] zone;
        logic [hrz_pkg::PCT_W-1:0]  pct;
    } t_plan_row;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [hrz_pkg::CIDX_W-1:0] i_cfg_idx = '0;
    logic [hrz_pkg::CDAT_W-1:0] i_cfg_data = '0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic [hrz_pkg::HR_W-1:0]   i_heart_rate = '0;
    logic [hrz_pkg::TIME_W-1:0] i_now_seconds = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic [hrz_pkg::ZONE_W-1:0] o_zone_number;
    logic [hrz_pkg::SECS_W-1:0] o_zone_seconds;
    logic [hrz_pkg::PCT_W-1:0]  o_percent_of_max;
    logic                       o_vibrate;

    // predictor copy of registers and tracking state
    logic [hrz_pkg::HR_W-1:0]   cfg_max;
    logic [hrz_pkg::MODE_W-1:0] cfg_mode;
    logic [hrz_pkg::HR_W-1:0]   cfg_dwell;
    logic [hrz_pkg::TIME_W-1:0] last_stamp;
    logic [hrz_pkg::ZONE_W-1:0] cur_zone;
    logic [hrz_pkg::TIME_W-1:0] zone_start;
    logic [hrz_pkg::SECS_W-1:0] zone_time [hrz_pkg::NUM_ZONES];

    t_zone_result zone_q[$];
    t_zone_result want_res;
    t_plan_row    plan[$];

    int unsigned cycles = 0;
    int unsigned n_err = 0;
    int unsigned n_checked = 0;
    int unsigned n_valid = 0;
    int unsigned n_dropped = 0;
    int unsigned n_writes = 0;
    int unsigned n_vib = 0;
    int unsigned n_sat = 0;
    int unsigned src_idle = 0;
    int unsigned snk_idle = 0;
    logic [hrz_pkg::TIME_W-1:0] stamp;

    heart_rate_zone_tracker dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_heart_rate    (i_heart_rate),
        .i_now_seconds   (i_now_seconds),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_zone_number   (o_zone_number),
        .o_zone_seconds  (o_zone_seconds),
        .o_percent_of_max(o_percent_of_max),
        .o_vibrate       (o_vibrate)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles, zone_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= snk_idle);
    end

    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        if (n_err < PRINT_CAP)
            $display("ERROR @%0t %s: expected %0d, got %0d", $time, what, want, got);
        n_err++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (zone_q.size() == 0) begin
                report_mismatch("result with nothing expected, zone", 0, o_zone_number);
            end else begin
                want_res = zone_q.pop_front();
                n_checked++;
                if (o_zone_number !== want_res.zone)
                    report_mismatch("zone_number", want_res.zone, o_zone_number);
                if (o_zone_seconds !== want_res.secs)
                    report_mismatch("zone_seconds", want_res.secs, o_zone_seconds);
                if (o_percent_of_max !== want_res.pct)
                    report_mismatch("percent_of_max", want_res.pct, o_percent_of_max);
                if (o_vibrate !== want_res.vib)
                    report_mismatch("vibrate", want_res.vib, o_vibrate);
                if (o_vibrate === 1'b1) n_vib++;
                if (o_zone_seconds === hrz_pkg::DELTA_SAT) n_sat++;
            end
        end
    end

    task automatic reset_tracker();
        cfg_max    = hrz_pkg::RST_MAX_HR;
        cfg_mode   = hrz_pkg::RST_MODE;
        cfg_dwell  = hrz_pkg::RST_DWELL;
        last_stamp = '0;
        cur_zone   = '0;
        zone_start = '0;
        for (int z = 0; z < hrz_pkg::NUM_ZONES; z++) zone_time[z] = '0;
    endtask

    // add seconds to one zone total, holding at all ones
    task automatic charge_zone(input logic [hrz_pkg::ZONE_W-1:0] z,
                               input logic [hrz_pkg::SECS_W-1:0] d);
        logic [hrz_pkg::SECS_W:0] sum;
        if (z < hrz_pkg::NUM_ZONES) begin
            sum = {1'b0, zone_time[z]} + {1'b0, d};
            zone_time[z] = sum[hrz_pkg::SECS_W] ? hrz_pkg::DELTA_SAT
                                                : sum[hrz_pkg::SECS_W-1:0];
        end
    endtask

    task automatic track_sample(input logic [hrz_pkg::HR_W-1:0] hr,
                                input logic [hrz_pkg::TIME_W-1:0] now,
                                output bit gives, output t_zone_result r);
        int unsigned                pct_full;
        logic [hrz_pkg::PCT_W-1:0]  pct;
        logic [hrz_pkg::ZONE_W-1:0] zone;
        logic [hrz_pkg::TIME_W-1:0] gap;
        logic [hrz_pkg::TIME_W-1:0] dwell_gap;
        logic [hrz_pkg::SECS_W-1:0] delta;
        logic                       vib;
        gives = 1'b0;
        r = '0;
        if (hr != hrz_pkg::HR_INVALID_LO && hr != hrz_pkg::HR_INVALID_HI) begin
            gives = 1'b1;
            if (cfg_max == 0) begin
                pct = hrz_pkg::PCT_SAT;
            end else begin
                pct_full = (32'd100 * hr) / cfg_max;
                pct = (pct_full > hrz_pkg::PCT_SAT) ? hrz_pkg::PCT_SAT
                                                    : pct_full[hrz_pkg::PCT_W-1:0];
            end
            if (pct < hrz_pkg::PCT_ZONE2)       zone = hrz_pkg::ZONE_1;
            else if (pct >= hrz_pkg::PCT_ZONE5) zone = hrz_pkg::ZONE_5;
            else                                zone = hrz_pkg::ZONE_W'(pct / 8'd10 - 8'd4);
            delta = '0;
            if (last_stamp != 0) begin
                gap = now - last_stamp;
                delta = (gap > hrz_pkg::TIME_W'(hrz_pkg::DELTA_SAT)) ? hrz_pkg::DELTA_SAT
                                                                     : gap[hrz_pkg::SECS_W-1:0];
            end
            vib = 1'b0;
            if (zone != cur_zone) begin
                dwell_gap = now - zone_start;
                if (cfg_mode == hrz_pkg::MODE_DWELL && zone_start != 0 && dwell_gap > cfg_dwell)
                    vib = 1'b1;
                if (cfg_mode == hrz_pkg::MODE_PEAK && zone == hrz_pkg::ZONE_5)
                    vib = 1'b1;
                // both the zone left and the zone entered are charged
                charge_zone(cur_zone, delta);
                cur_zone   = zone;
                zone_start = now;
            end
            last_stamp = now;
            charge_zone(zone, delta);
            r.zone = zone;
            r.secs = zone_time[zone];
            r.pct  = pct;
            r.vib  = vib;
        end
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_sample(input logic [hrz_pkg::HR_W-1:0] hr,
                               input logic [hrz_pkg::TIME_W-1:0] now,
                               input bit typed, input logic [hrz_pkg::ZONE_W-1:0] zone,
                               input logic [hrz_pkg::PCT_W-1:0] pct);
        t_zone_result r;
        bit           gives;
        while ($urandom_range(99) < src_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_heart_rate  <= hr;
        i_now_seconds <= now;
        do @(posedge i_clk); while (!o_ready);
        track_sample(hr, now, gives, r);
        if (gives) begin
            if (typed) begin
                r.zone = zone;
                r.pct  = pct;
            end
            zone_q.push_back(r);
            n_valid++;
        end else begin
            n_dropped++;
        end
        @(negedge i_clk);
    endtask

    // hold the sender until every result is in, then let a dropped item clear
    task automatic drain();
        i_valid <= 1'b0;
        while (zone_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [hrz_pkg::CIDX_W-1:0] idx,
                             input logic [hrz_pkg::CDAT_W-1:0] data);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            hrz_pkg::REG_MAX_HR: cfg_max   = data;
            hrz_pkg::REG_MODE:   cfg_mode  = data[hrz_pkg::MODE_W-1:0];
            hrz_pkg::REG_DWELL:  cfg_dwell = data;
            default: ;
        endcase
        n_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic void add_sample(input logic [hrz_pkg::HR_W-1:0] hr,
                                       input logic [hrz_pkg::TIME_W-1:0] t,
                                       input bit typed, input logic [hrz_pkg::ZONE_W-1:0] zone,
                                       input logic [hrz_pkg::PCT_W-1:0] pct);
        t_plan_row r;
        r.kind  = ROW_SAMPLE;
        r.hr    = hr;
        r.stamp = t;
        r.idx   = '0;
        r.data  = '0;
        r.typed = typed;
        r.zone  = zone;
        r.pct   = pct;
        plan.push_back(r);
    endfunction

    function automatic void add_write(input logic [hrz_pkg::CIDX_W-1:0] idx,
                                      input logic [hrz_pkg::CDAT_W-1:0] data);
        t_plan_row r;
        r.kind  = ROW_WRITE;
        r.hr    = '0;
        r.stamp = '0;
        r.idx   = idx;
        r.data  = data;
        r.typed = 1'b0;
        r.zone  = '0;
        r.pct   = '0;
        plan.push_back(r);
    endfunction

    // aim most rates at a percent band around the zone edges
    function automatic logic [hrz_pkg::HR_W-1:0] pick_rate();
        int unsigned p;
        int unsigned v;
        if (cfg_max == 0 || $urandom_range(99) < 15) begin
            v = $urandom_range(1, 254);
        end else begin
            p = $urandom_range(40, 115);
            v = (p * cfg_max) / 100 + $urandom_range(0, 2);
            if (v < 1) v = 1;
            if (v > 254) v = 254;
        end
        return v[hrz_pkg::HR_W-1:0];
    endfunction

    task automatic advance_stamp();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 2)       stamp = stamp - $urandom_range(1, 5000);
        else if (roll < 4)  stamp = $urandom();
        else if (roll == 4) stamp = '0;
        else                stamp = stamp + $urandom_range(0, 45);
    endtask

    task automatic run_segment(input int seg);
        int unsigned                sent;
        bit                         held;
        logic [hrz_pkg::CDAT_W-1:0] mx;
        logic [hrz_pkg::CDAT_W-1:0] dw;
        logic [hrz_pkg::MODE_W-1:0] md;
        sent = 0;
        held = 1'b0;
        src_idle = (seg < 3) ? 25 : (seg < 6) ? 82 : 0;
        snk_idle = (seg < 3) ? 82 : (seg < 6) ? 25 : 0;
        case (seg)
            1:       mx = 8'd255;
            4:       mx = 8'd60;
            default: mx = hrz_pkg::CDAT_W'($urandom_range(120, 220));
        endcase
        case (seg)
            1, 5:    md = hrz_pkg::MODE_PEAK;
            3:       md = hrz_pkg::MODE_OFF;
            6:       md = MODE_UNUSED;
            default: md = hrz_pkg::MODE_DWELL;
        endcase
        case (seg)
            2:       dw = 8'd0;
            5:       dw = 8'd255;
            default: dw = hrz_pkg::CDAT_W'($urandom_range(0, 60));
        endcase
        write_reg(hrz_pkg::REG_MAX_HR, mx);
        write_reg(hrz_pkg::REG_MODE, hrz_pkg::CDAT_W'(md));
        write_reg(hrz_pkg::REG_DWELL, dw);
        stamp = $urandom();
        while (sent < SEG_SAMPLES) begin
            advance_stamp();
            if ($urandom_range(99) < 5) begin
                send_sample($urandom_range(1) ? hrz_pkg::HR_INVALID_HI : hrz_pkg::HR_INVALID_LO,
                            stamp, 1'b0, '0, '0);
            end else begin
                send_sample(pick_rate(), stamp, 1'b0, '0, '0);
                sent++;
            end
            if (seg == 1 && sent == SEG_SAMPLES / 2 && !held) begin
                held = 1'b1;
                drain();
            end
        end
    endtask

    initial begin
        reset_tracker();
        src_idle = 25;
        snk_idle = 82;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        add_sample(hrz_pkg::HR_INVALID_LO, 32'd5, 1'b0, '0, '0);
        add_sample(hrz_pkg::HR_INVALID_HI, 32'd7, 1'b0, '0, '0);
        add_sample(8'd95,  32'd100, 1'b1, hrz_pkg::ZONE_1, 8'd50);
        add_sample(8'd114, 32'd110, 1'b1, hrz_pkg::ZONE_2, 8'd60);
        add_sample(8'd133, 32'd120, 1'b1, hrz_pkg::ZONE_3, 8'd70);
        add_sample(8'd152, 32'd130, 1'b1, hrz_pkg::ZONE_4, 8'd80);
        add_sample(8'd171, 32'd140, 1'b1, hrz_pkg::ZONE_5, 8'd90);
        add_sample(8'd254, 32'd150, 1'b1, hrz_pkg::ZONE_5, 8'd133);
        add_sample(8'd1,   32'd150, 1'b1, hrz_pkg::ZONE_1, 8'd0);
        // timestamp runs backwards: elapsed time holds at its top
        add_sample(8'd100, 32'd50,  1'b1, hrz_pkg::ZONE_1, 8'd52);
        // a zero stamp makes the next sample count as the first
        add_sample(8'd100, 32'd0,   1'b0, '0, '0);
        add_sample(8'd100, 32'd1000, 1'b0, '0, '0);
        add_sample(8'd200, 32'hFFFF_FFFF, 1'b1, hrz_pkg::ZONE_5, 8'd105);
        add_write(hrz_pkg::REG_MODE, hrz_pkg::CDAT_W'(hrz_pkg::MODE_DWELL));
        add_write(hrz_pkg::REG_DWELL, 8'd0);
        add_sample(8'd95,  32'h10, 1'b0, '0, '0);
        add_sample(8'd95,  32'h20, 1'b0, '0, '0);
        add_write(hrz_pkg::REG_DWELL, 8'd255);
        add_sample(8'd171, 32'h30, 1'b0, '0, '0);
        add_write(hrz_pkg::REG_MAX_HR, 8'd255);
        add_write(hrz_pkg::REG_MODE, hrz_pkg::CDAT_W'(hrz_pkg::MODE_PEAK));
        add_sample(8'd254, 32'h40, 1'b1, hrz_pkg::ZONE_5, 8'd99);
        add_sample(8'd153, 32'h50, 1'b1, hrz_pkg::ZONE_2, 8'd60);
        add_sample(8'd230, 32'h60, 1'b1, hrz_pkg::ZONE_5, 8'd90);
        add_write(hrz_pkg::REG_MAX_HR, 8'd1);
        add_sample(8'd3,   32'h70, 1'b1, hrz_pkg::ZONE_5, hrz_pkg::PCT_SAT);
        // zero maximum saturates the percent
        add_write(hrz_pkg::REG_MAX_HR, 8'd0);
        add_sample(8'd2,   32'h80, 1'b1, hrz_pkg::ZONE_5, hrz_pkg::PCT_SAT);
        add_write(hrz_pkg::REG_MODE, hrz_pkg::CDAT_W'(MODE_UNUSED));
        add_write(REG_UNUSED, 8'hA5);
        add_write(hrz_pkg::REG_MAX_HR, 8'd200);
        add_sample(8'd100, 32'h90, 1'b1, hrz_pkg::ZONE_1, 8'd50);
        add_sample(8'd180, 32'hA0, 1'b1, hrz_pkg::ZONE_5, 8'd90);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE)
                write_reg(plan[i].idx, plan[i].data);
            else
                send_sample(plan[i].hr, plan[i].stamp, plan[i].typed,
                            plan[i].zone, plan[i].pct);
        end

        for (int seg = 0; seg < SEGMENTS; seg++) run_segment(seg);
        drain();

        $display("Covered %0d valid samples (%0d results checked), %0d invalid dropped,",
                 n_valid, n_checked, n_dropped);
        $display("%0d writes; saw %0d vibrate requests, %0d saturated zone totals, %0d mismatches",
                 n_writes, n_vib, n_sat, n_err);
        if (n_err == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
